@@ hw/rtl/sha256_pkg.sv @@
// Shared constants, tables, a control type and a helper function for the SHA-256 message hash.
package sha256_pkg;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Control from the sequencer to the compression core.
    typedef struct packed {
        logic       start;
        logic       run;
        logic [5:0] round;
    } core_ctrl_t;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        ror = (v >> s) | (v << (32 - s));
    endfunction

endpackage

@@ hw/rtl/sha256_core.sv @@
// Round engine: schedule tap line, working variables and chain update.
module sha256_core
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctrl_t  ctrl,
    input  logic        chain_init,
    input  logic [31:0] blk_word,
    output logic [31:0] chain [8]
);

    // Schedule window as a 16-word tap line: hist_reg[k] holds w[t-1-k], so
    // w[t-2], w[t-7], w[t-15] and w[t-16] are read at fixed places.
    logic [31:0] hist_reg [16];
    logic [31:0] wv_reg [8];
    logic [31:0] chain_reg [8];
    logic [31:0] w_cur, s0, s1, t1, t2, a, e;
    logic        add_reg;

    always_comb
    begin
        s1 = ror(hist_reg[1], 17) ^ ror(hist_reg[1], 19) ^ (hist_reg[1] >> 10);
        s0 = ror(hist_reg[14], 7) ^ ror(hist_reg[14], 18) ^ (hist_reg[14] >> 3);
        if (ctrl.round < 6'd16)
        begin
            w_cur = blk_word;
        end
        else
        begin
            w_cur = s1 + hist_reg[6] + s0 + hist_reg[15];
        end
        a  = wv_reg[0];
        e  = wv_reg[4];
        t1 = wv_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & wv_reg[5]) ^ (~e & wv_reg[6])) + ROUND_K[ctrl.round] + w_cur;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & wv_reg[1]) ^ (a & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.run)
        begin
            hist_reg[0] <= w_cur;
            for (int i = 1; i < 16; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    // Add the working variables into the chain the cycle after round 63.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            add_reg <= ctrl.run && (ctrl.round == 6'd63);
            if (chain_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= INIT_HASH[i];
                end
            end
            else if (add_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + wv_reg[i];
                end
            end
        end
    end

    assign chain = chain_reg;

endmodule

@@ hw/rtl/sha256_message_hash.sv @@
// Top level of the byte-fed SHA-256 message hash.
// Feed one message byte per item on s_axis (tdata = data_byte, tuser bit 0 =
// byte_present, tlast = last_byte). Bytes are packed big-endian into a 16-word
// block memory; items are taken only while the block is filling. Every
// 64th byte starts a compression: a start step, 64 rounds at one round a
// cycle and a chain update, and input is held off meanwhile. On a last item
// the block writes the 0x80 pad, zero fill and the 64-bit bit length one word
// per cycle into the block memory, compresses one or two blocks, depending on
// where the pad byte falls, then loads the eight digest words into an output
// register and restores the initial hash. m_axis_tdata carries digest_word0
// in the lowest bits. The output register frees the input while a digest
// waits; only a second digest that finds the register still full holds the
// block. The round loop of the compression core sets the rate.
module sha256_message_hash
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // byte_present
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata    // digest_word0 (bits 31:0) .. digest_word7
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_COMP = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [63:0]  count_reg;
    logic [5:0]   fill_reg;
    logic [6:0]   round_reg;
    logic         final_reg;       // compression is the last one of the message
    logic         pad_done_reg;    // 0x80 already written
    logic         pad_active_reg;  // message has ended, padding under way
    logic         out_valid_reg;
    logic [255:0] out_data_reg;
    logic [31:0]  blk_mem [16];
    logic [31:0]  blk_rd;
    logic [31:0]  chain [8];
    logic         chain_init;
    logic         load_out;
    core_ctrl_t   ctrl;

    logic        acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Load the digest once the output register is free or being emptied.
    assign load_out   = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign chain_init = load_out;

    // Block memory: byte writes from the input, pad/len word writes, and one
    // registered read, addressed one round ahead of the round that uses it.
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  wr_be;
    logic [3:0]  rd_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = '0;
        wr_be   = '0;
        if (acc && s_axis_tuser)
        begin
            wr_en   = 1'b1;
            wr_data = {4{s_axis_tdata}};
            wr_be   = 4'b1000 >> fill_reg[1:0];
        end
        else if (state_reg == ST_PAD)
        begin
            wr_en = 1'b1;
            if (pad_done_reg)
            begin
                // Zero a whole word.
                wr_data = '0;
                wr_be   = 4'hf;
            end
            else
            begin
                // Pad byte at the fill point, zeros in the rest of its word.
                wr_data = {PAD_BYTE, 24'h0} >> {fill_reg[1:0], 3'b000};
                wr_be   = 4'b1111 >> fill_reg[1:0];
            end
        end
        else if (state_reg == ST_LEN)
        begin
            wr_en   = 1'b1;
            wr_addr = {3'b111, fill_reg[2]};
            wr_data = fill_reg[2] ? count_reg[31:0] : count_reg[63:32];
            wr_be   = 4'hf;
        end
    end

    assign rd_addr = (state_reg == ST_COMP) ? round_reg[3:0] : 4'd0;

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (wr_en && wr_be[b])
            begin
                blk_mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
            end
        end
        blk_rd <= blk_mem[rd_addr];
    end

    // Rounds run while round_reg is 1..64; round 0 of the core is fed from the
    // read issued in the start cycle.
    assign ctrl.start = (state_reg == ST_COMP) && (round_reg == 7'd0);
    assign ctrl.run   = (state_reg == ST_COMP) && (round_reg != 7'd0);
    assign ctrl.round = round_reg[5:0] - 6'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (s_axis_tuser && fill_reg == 6'd63)
                        state_next = ST_COMP;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // Word 13 done: length follows; word 15 done: block is full.
                if (fill_reg[5:2] == 4'd13)
                    state_next = ST_LEN;
                else if (fill_reg[5:2] == 4'd15)
                    state_next = ST_COMP;
            end
            ST_LEN:    if (fill_reg[2]) state_next = ST_COMP;
            ST_COMP:   if (round_reg == 7'd64) state_next = ST_WAIT;
            ST_WAIT:   state_next = final_reg ? ST_OUT
                                  : (pad_active_reg ? ST_PAD : ST_IDLE);
            ST_OUT:    if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            fill_reg       <= '0;
            round_reg      <= '0;
            final_reg      <= 1'b0;
            pad_done_reg   <= 1'b0;
            pad_active_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        if (s_axis_tuser)
                        begin
                            count_reg <= count_reg + 64'd8;
                            fill_reg  <= fill_reg + 6'd1;
                        end
                        // A last item that fills the block pads after compressing.
                        pad_active_reg <= s_axis_tlast;
                    end
                end
                ST_PAD:
                begin
                    // Advance to the next word; it wraps to zero after word 15.
                    pad_done_reg <= 1'b1;
                    fill_reg     <= {fill_reg[5:2] + 4'd1, 2'b00};
                end
                ST_LEN:
                begin
                    if (!fill_reg[2])
                        fill_reg <= 6'd60;
                    else
                    begin
                        fill_reg  <= '0;
                        final_reg <= 1'b1;
                    end
                end
                ST_COMP:
                begin
                    round_reg <= (round_reg == 7'd64) ? 7'd0 : round_reg + 7'd1;
                end
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        count_reg      <= '0;
                        fill_reg       <= '0;
                        final_reg      <= 1'b0;
                        pad_done_reg   <= 1'b0;
                        pad_active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: hold the digest until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {chain[7], chain[6], chain[5], chain[4],
                              chain[3], chain[2], chain[1], chain[0]};
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    sha256_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .chain_init (chain_init),
        .blk_word   (blk_rd),
        .chain      (chain)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> !s_axis_tready)
        else $error("input taken during compression");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("digest changed while stalled");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("digest dropped while stalled");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= 7'd64)
        else $error("round counter out of range");
`endif

endmodule
